/* hw/rtl/bba_pkg.sv */
`timescale 1ns / 1ps
// Shared types and codes for the bitmap block allocator.
// No dependencies; imported by bba_fmt_mask and bitmap_block_allocator_unit.
package bba_pkg;

  localparam logic [1:0] MODE_ALLOC  = 2'd0;
  localparam logic [1:0] MODE_FREE   = 2'd1;
  localparam logic [1:0] MODE_FORMAT = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_FREE = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;

  localparam logic [2:0] REG_TOTAL       = 3'd0;
  localparam logic [2:0] REG_MAP_START   = 3'd1;
  localparam logic [2:0] REG_MAP_COUNT   = 3'd2;
  localparam logic [2:0] REG_INODE_START = 3'd3;
  localparam logic [2:0] REG_INODE_COUNT = 3'd4;

  localparam int INDEX_SPAN = 65536;

  typedef struct packed {
    logic [15:0] map_start;
    logic [15:0] map_count;
    logic [15:0] inode_start;
    logic [15:0] inode_len;
  } bba_fmt_cfg_t;

endpackage

/* hw/rtl/bitmap_block_allocator_unit.sv */
`timescale 1ns / 1ps
// Bitmap first-fit block allocator: one used bit per block in a word RAM.
// Depends on bba_pkg, bba_ram and bba_fmt_mask.
//
// Requests enter on s_axis (tuser = mode, tdata = block index); one reply per
// request leaves on m_axis (tuser = status, tdata = granted block).
// Mode allocate takes the lowest free block below min(block total, MAX_BLOCKS,
// 65536); free clears one bit; format rewrites the whole map with block 0, the
// map blocks and the inode blocks reserved.
// One request is in work at a time. Allocate reads and checks the word under the
// search pointer and replies when that word has a free bit; each full word skipped
// costs one more RAM read and one more check before the next word. The search
// pointer only moves back on a free or a format. Free steps through a reciprocal
// divide, a read, a write and a reply. Format sweeps the whole map, one RAM
// word written per cycle, then replies.
// After reset the RAM is cleared one word a cycle, all MAP_WORDS words
// (2048 with the defaults), while s_axis_tready stays low.
// The reply sits in an output register; a new request is accepted while it
// waits, and the next reply holds in its final state until m_axis_tready.
// Configuration writes (cfg_wen) take effect at once, no read-back.
module bitmap_block_allocator_unit #(
  parameter int MAX_BLOCKS = 65536,
  parameter int WORD_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] block_index
  input  logic [1:0]  s_axis_tuser,   // [1:0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] granted_block
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  input  logic        cfg_wen,
  input  logic [2:0]  cfg_addr,
  input  logic [16:0] cfg_wdata
);

  import bba_pkg::*;

  localparam int MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int WADDR     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int HW        = WADDR + 1;
  localparam int BASE_W    = $clog2(MAP_WORDS * WORD_BITS + 1);
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int CW        = ((BASE_W > 17) ? BASE_W : 17) + 1;
  localparam int LIM_CAP   = (MAX_BLOCKS < INDEX_SPAN) ? MAX_BLOCKS : INDEX_SPAN;
  localparam int DIV_SH    = 16 + BIT_W;
  localparam int RECIP     = ((1 << DIV_SH) + WORD_BITS - 1) / WORD_BITS;
  localparam int PW        = DIV_SH + 16;

  typedef enum logic [2:0] {
    S_SWEEP, S_IDLE, S_ALLOC_RD, S_ALLOC_CHK, S_FREE_DIV, S_FREE_RD, S_FREE_WR, S_DONE
  } state_t;

  state_t state;

  logic [16:0] block_total;
  bba_fmt_cfg_t fmt_cfg;
  logic [16:0] lim;

  logic             sweep_clear;
  logic [WADDR-1:0] sweep_w;
  logic [BASE_W-1:0] sweep_base;

  logic [HW-1:0]     hint;
  logic [BASE_W-1:0] hint_base;
  logic [HW-1:0]     scan_w;
  logic [BASE_W-1:0] scan_base;

  logic [15:0]       req_idx;
  logic [15:0]       quot;
  logic [BIT_W-1:0]  free_bit;
  logic [BASE_W-1:0] free_base;

  logic [1:0]  res_status;
  logic [15:0] res_grant;

  logic                 ram_wen;
  logic [WADDR-1:0]     ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                 ram_ren;
  logic [WADDR-1:0]     ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;
  logic [WORD_BITS-1:0] fmt_mask;

  logic [WORD_BITS-1:0] free_bits;
  logic [WORD_BITS-1:0] low_bit;
  logic [BIT_W-1:0]     low_pos;
  logic [CW-1:0]        cand_blk;
  logic [PW-1:0]        div_prod;
  logic [23:0]          quot_base;

  bba_fmt_mask #(
    .WORD_BITS  (WORD_BITS),
    .MAX_BLOCKS (MAX_BLOCKS),
    .BASE_W     (BASE_W)
  ) u_fmt_mask (
    .base (sweep_base),
    .cfg  (fmt_cfg),
    .mask (fmt_mask)
  );

  bba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map_ram (
    .clk   (clk),
    .wen   (ram_wen),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .ren   (ram_ren),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign lim = (block_total > 17'(LIM_CAP)) ? 17'(LIM_CAP) : block_total;
  assign s_axis_tready = (state == S_IDLE);

  always_comb begin
    free_bits = ~ram_rdata;
    low_bit   = free_bits & (~free_bits + 1'b1);
    low_pos   = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      if (low_bit[j]) begin
        low_pos = low_pos | BIT_W'(j);
      end
    end
    cand_blk  = CW'(scan_base) + CW'(low_pos);
    div_prod  = PW'(req_idx) * PW'(RECIP);
    quot_base = 24'(quot) * 24'(WORD_BITS);
  end

  always_comb begin
    ram_wen   = 1'b0;
    ram_waddr = sweep_w;
    ram_wdata = sweep_clear ? '0 : fmt_mask;
    ram_ren   = 1'b0;
    ram_raddr = scan_w[WADDR-1:0];
    case (state)
      S_SWEEP: begin
        ram_wen = 1'b1;
      end
      S_ALLOC_RD: begin
        ram_ren = 1'b1;
      end
      S_ALLOC_CHK: begin
        ram_waddr = scan_w[WADDR-1:0];
        ram_wdata = ram_rdata | low_bit;
        ram_wen   = (free_bits != '0) && (cand_blk < CW'(lim));
      end
      S_FREE_RD: begin
        ram_ren   = 1'b1;
        ram_raddr = WADDR'(quot);
      end
      S_FREE_WR: begin
        ram_wen   = 1'b1;
        ram_waddr = WADDR'(quot);
        ram_wdata = ram_rdata & ~({{(WORD_BITS-1){1'b0}}, 1'b1} << free_bit);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_SWEEP;
      sweep_clear   <= 1'b1;
      sweep_w       <= '0;
      sweep_base    <= '0;
      hint          <= '0;
      hint_base     <= '0;
      m_axis_tvalid <= 1'b0;
      block_total   <= 17'd65536;
      fmt_cfg.map_start   <= 16'd1;
      fmt_cfg.map_count   <= 16'd1;
      fmt_cfg.inode_start <= 16'd2;
      fmt_cfg.inode_len   <= 16'd1;
    end else begin
      if (cfg_wen) begin
        case (cfg_addr)
          REG_TOTAL:       block_total         <= cfg_wdata;
          REG_MAP_START:   fmt_cfg.map_start   <= cfg_wdata[15:0];
          REG_MAP_COUNT:   fmt_cfg.map_count   <= cfg_wdata[15:0];
          REG_INODE_START: fmt_cfg.inode_start <= cfg_wdata[15:0];
          REG_INODE_COUNT: fmt_cfg.inode_len   <= cfg_wdata[15:0];
          default: begin
          end
        endcase
      end

      if (m_axis_tready && (state != S_DONE)) begin
        m_axis_tvalid <= 1'b0;
      end

      case (state)
        S_SWEEP: begin
          sweep_w    <= sweep_w + 1'b1;
          sweep_base <= sweep_base + BASE_W'(WORD_BITS);
          if (sweep_w == WADDR'(MAP_WORDS - 1)) begin
            state <= sweep_clear ? S_IDLE : S_DONE;
          end
        end
        S_IDLE: begin
          if (s_axis_tvalid) begin
            req_idx    <= s_axis_tdata;
            res_status <= ST_OK;
            res_grant  <= '0;
            scan_w     <= hint;
            scan_base  <= hint_base;
            case (s_axis_tuser)
              MODE_ALLOC: state <= S_ALLOC_RD;
              MODE_FREE:  state <= S_FREE_DIV;
              MODE_FORMAT: begin
                state       <= S_SWEEP;
                sweep_clear <= 1'b0;
                sweep_w     <= '0;
                sweep_base  <= '0;
                hint        <= '0;
                hint_base   <= '0;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_ALLOC_RD: begin
          if (scan_w >= HW'(MAP_WORDS) || CW'(scan_base) >= CW'(lim)) begin
            res_status <= ST_NO_FREE;
            state      <= S_DONE;
          end else begin
            state <= S_ALLOC_CHK;
          end
        end
        S_ALLOC_CHK: begin
          if (free_bits != '0) begin
            hint      <= scan_w;
            hint_base <= scan_base;
            if (cand_blk < CW'(lim)) begin
              res_grant <= cand_blk[15:0];
            end else begin
              res_status <= ST_NO_FREE;
            end
            state <= S_DONE;
          end else begin
            hint      <= scan_w + 1'b1;
            hint_base <= scan_base + BASE_W'(WORD_BITS);
            scan_w    <= scan_w + 1'b1;
            scan_base <= scan_base + BASE_W'(WORD_BITS);
            state     <= S_ALLOC_RD;
          end
        end
        S_FREE_DIV: begin
          if (17'(req_idx) >= lim) begin
            res_status <= ST_RANGE;
            state      <= S_DONE;
          end else begin
            quot  <= div_prod[DIV_SH +: 16];
            state <= S_FREE_RD;
          end
        end
        S_FREE_RD: begin
          free_bit  <= BIT_W'(24'(req_idx) - quot_base);
          free_base <= BASE_W'(quot_base);
          state     <= S_FREE_WR;
        end
        S_FREE_WR: begin
          if (HW'(quot) < hint) begin
            hint      <= HW'(quot);
            hint_base <= free_base;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tuser  <= res_status;
            m_axis_tdata  <= res_grant;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_grant_zero_unless_ok: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser != ST_OK) |-> (m_axis_tdata == '0))
    else $error("non-ok reply carries a block number");

  a_hint_base_tracks: assert property (@(posedge clk) disable iff (rst)
    hint_base == BASE_W'(hint * WORD_BITS))
    else $error("search pointer base out of step with word index");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second request taken while one is in work");

  a_check_after_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_ALLOC_CHK) |-> ($past(state) == S_ALLOC_RD))
    else $error("map word checked without a fresh read");

endmodule

/* hw/rtl/bba_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wen,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             ren,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    if (ren) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/bba_fmt_mask.sv */
`timescale 1ns / 1ps
// Reserved-block mask of one map word for a format sweep.
// Depends on bba_pkg (bba_fmt_cfg_t).
module bba_fmt_mask #(
  parameter int WORD_BITS  = 32,
  parameter int MAX_BLOCKS = 65536,
  parameter int BASE_W     = 17
) (
  input  logic [BASE_W-1:0]      base,
  input  bba_pkg::bba_fmt_cfg_t  cfg,
  output logic [WORD_BITS-1:0]   mask
);

  import bba_pkg::*;

  localparam int DW = ((BASE_W > 17) ? BASE_W : 17) + 2;
  localparam int KW = $clog2(WORD_BITS + 1);

  function automatic logic [KW-1:0] clip(input logic signed [DW-1:0] x,
                                         input logic signed [DW-1:0] top);
    logic [KW-1:0] r;
    if (x <= 0) begin
      r = '0;
    end else if (x >= top) begin
      r = KW'(top);
    end else begin
      r = KW'(x);
    end
    return r;
  endfunction

  function automatic logic [WORD_BITS-1:0] ones(input logic [KW-1:0] k);
    logic [WORD_BITS-1:0] r;
    if (k >= KW'(WORD_BITS)) begin
      r = '1;
    end else begin
      r = ~({WORD_BITS{1'b1}} << k);
    end
    return r;
  endfunction

  logic signed [DW-1:0] base_s;
  logic signed [DW-1:0] cap;
  logic signed [DW-1:0] top;
  logic signed [DW-1:0] full;
  logic signed [DW-1:0] map_lo;
  logic signed [DW-1:0] map_hi;
  logic signed [DW-1:0] ino_lo;
  logic signed [DW-1:0] ino_hi;
  logic [WORD_BITS-1:0] map_mask;
  logic [WORD_BITS-1:0] ino_mask;
  logic [WORD_BITS-1:0] blk0_mask;

  always_comb begin
    base_s = $signed(DW'(base));
    full   = $signed(DW'(WORD_BITS));
    cap    = $signed(DW'(MAX_BLOCKS)) - base_s;
    top    = (cap < full) ? cap : full;
    map_lo = $signed(DW'(cfg.map_start)) - base_s;
    map_hi = $signed(DW'(cfg.map_start)) + $signed(DW'(cfg.map_count)) - base_s;
    ino_lo = $signed(DW'(cfg.inode_start)) - base_s;
    ino_hi = $signed(DW'(cfg.inode_start)) + $signed(DW'(cfg.inode_len)) - base_s;
    map_mask  = ones(clip(map_hi, top)) & ~ones(clip(map_lo, full));
    ino_mask  = ones(clip(ino_hi, top)) & ~ones(clip(ino_lo, full));
    blk0_mask = (base == '0) ? {{(WORD_BITS-1){1'b0}}, 1'b1} : '0;
    mask = map_mask | ino_mask | blk0_mask;
  end

endmodule
